/* design/ili_pkg.sv */
// Package for the indexed list block: sizes, command and status codes,
// cell control word. No dependencies.
`default_nettype none

package ili_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;

    // Fixed field widths of the command and result words
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HELD_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (HELD_W > INDEX_W) ? HELD_W : INDEX_W;

    // Read tree: cells are OR-ed in groups, groups registered, then OR-ed
    localparam int GROUP = 8;
    localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_ERASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic                   rd_en;
        logic [POS_W-1:0]       idx;
        logic [WORD_BITS-1:0]   value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

/* design/ili_if.sv */
// Valid/ready channels of the indexed list block: command word and result word.
// Depends on ili_pkg.
`default_nettype none

interface ili_cmd_if import ili_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [CMD_W-1:0]            cmd;
    logic [INDEX_W-1:0]          index;
    logic signed [VALUE_W-1:0]   value;

    modport source (output valid, output cmd, output index, output value, input ready);
    modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface ili_res_if import ili_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [VALUE_W-1:0]   read_value;
    logic [COUNT_W-1:0]          count;
    logic [STAT_W-1:0]           status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

`default_nettype wire

/* design/ili_cell.sv */
// One list slot: holds a word, takes it from either neighbor on a shift.
// Depends on ili_pkg.
`default_nettype none

module ili_cell
    import ili_pkg::*;
(
    input  wire                   i_clk,
    input  var t_cell_ctl         i_ctl,
    input  wire [POS_W-1:0]       i_pos,
    input  wire [WORD_BITS-1:0]   i_left,
    input  wire [WORD_BITS-1:0]   i_right,
    output logic [WORD_BITS-1:0]  o_word,
    output logic [WORD_BITS-1:0]  o_rd
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_WRITE: begin
                if (i_pos == i_ctl.idx) n_word = i_ctl.value;
            end
            CELL_INSERT: begin
                if (i_pos > i_ctl.idx)       n_word = i_left;
                else if (i_pos == i_ctl.idx) n_word = i_ctl.value;
            end
            CELL_ERASE: begin
                if (i_pos >= i_ctl.idx) n_word = i_right;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    // gated so the read tree is a plain OR
    assign o_rd   = (i_ctl.rd_en && (i_pos == i_ctl.idx)) ? r_word : '0;

endmodule

`default_nettype wire

/* design/indexed_list_insert_erase.sv */
// Indexed list with insert and erase: a row of word cells that shift together.
// An accepted command goes through the execute and reduce states; the result is
// then held valid in the output state, and no new command is taken until it is.
// The two-level registered read tree and single result register set this pace.
// Reset (synchronous, active low) empties the list; word contents are not cleared.
// Depends on ili_pkg, ili_if, ili_cell.
`default_nettype none

module indexed_list_insert_erase
    import ili_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    ili_cmd_if.sink     i_cmd,
    ili_res_if.source   o_res
);

    t_state                 r_state, n_state;
    logic [CMD_W-1:0]       r_cmd;
    logic [INDEX_W-1:0]     r_idx;
    logic [WORD_BITS-1:0]   r_value;
    logic [HELD_W-1:0]      r_held, n_held;
    t_status                r_status, n_status;
    logic [WORD_BITS-1:0]   r_grp [NGRP];
    logic [WORD_BITS-1:0]   r_rd;

    t_cell_op               d_op;
    logic                   d_rd_en;
    logic [POS_W-1:0]       d_idx;
    t_cell_ctl              w_ctl;
    logic [WORD_BITS-1:0]   w_word [DEPTH];
    logic [WORD_BITS-1:0]   w_rd   [DEPTH];
    logic [WORD_BITS-1:0]   w_grp  [NGRP];
    logic [WORD_BITS-1:0]   w_rd_all;
    logic [CMP_W-1:0]       w_idx_c, w_held_c;
    logic                   w_full, w_empty, w_in_range;
    logic                   w_accept;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_idx_c    = CMP_W'(r_idx);
    assign w_held_c   = CMP_W'(r_held);
    assign w_full     = (r_held == HELD_W'(DEPTH));
    assign w_empty    = (r_held == '0);
    assign w_in_range = (w_idx_c < w_held_c);

    // command decode, used in the execute cycle
    always_comb begin
        d_op     = CELL_HOLD;
        d_rd_en  = 1'b0;
        d_idx    = POS_W'(r_idx);
        n_held   = r_held;
        n_status = STAT_DONE;
        case (t_cmd'(r_cmd))
            CMD_APPEND: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    d_op   = CELL_WRITE;
                    d_idx  = POS_W'(r_held);
                    n_held = r_held + HELD_W'(1);
                end
            end
            CMD_POP: begin
                if (w_empty) n_status = STAT_EMPTY;
                else         n_held   = r_held - HELD_W'(1);
            end
            CMD_INSERT: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else if (!w_in_range) begin
                    d_op   = CELL_WRITE;
                    d_idx  = POS_W'(r_held);
                    n_held = r_held + HELD_W'(1);
                end else begin
                    d_op   = CELL_INSERT;
                    n_held = r_held + HELD_W'(1);
                end
            end
            CMD_ERASE: begin
                if (!w_in_range) begin
                    n_status = STAT_RANGE;
                end else begin
                    d_op   = CELL_ERASE;
                    n_held = r_held - HELD_W'(1);
                end
            end
            CMD_READ: begin
                if (!w_in_range) n_status = STAT_RANGE;
                else             d_rd_en  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // FSM next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_EXEC;
            S_EXEC:   n_state = S_REDUCE;
            S_REDUCE: n_state = S_OUT;
            S_OUT:    if (o_res.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        i_cmd.ready = (r_state == S_IDLE);
        o_res.valid = (r_state == S_OUT);
        w_ctl.op    = (r_state == S_EXEC) ? d_op : CELL_HOLD;
        w_ctl.rd_en = (r_state == S_EXEC) && d_rd_en;
        w_ctl.idx   = d_idx;
        w_ctl.value = r_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd.cmd;
            r_idx   <= i_cmd.index;
            r_value <= WORD_BITS'($unsigned(i_cmd.value));
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_grp    <= w_grp;
        end
        if (r_state == S_REDUCE) r_rd <= w_rd_all;
    end

    // cell row; end cells see their own word at the open side
    for (genvar c = 0; c < DEPTH; c++) begin : g_cell
        ili_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (POS_W'(c)),
            .i_left  (w_word[(c > 0) ? c - 1 : c]),
            .i_right (w_word[(c < DEPTH - 1) ? c + 1 : c]),
            .o_word  (w_word[c]),
            .o_rd    (w_rd[c])
        );
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        always_comb begin
            w_grp[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < DEPTH) w_grp[g] = w_grp[g] | w_rd[g * GROUP + j];
            end
        end
    end

    always_comb begin
        w_rd_all = '0;
        for (int g = 0; g < NGRP; g++) w_rd_all = w_rd_all | r_grp[g];
    end

    assign o_res.read_value = VALUE_W'(r_rd);
    assign o_res.count      = COUNT_W'(r_held);
    assign o_res.status     = r_status;

    // checks
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(DEPTH))
        else $error("held count exceeds depth");

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !o_res.valid)
        else $error("command taken while a result word is pending");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_res.valid)
        else $error("result word not valid three cycles after accept");

    a_held_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_held == $past(r_held)) ||
                           (r_held == $past(r_held) + HELD_W'(1)) ||
                           (r_held == $past(r_held) - HELD_W'(1)))
        else $error("held count moved by more than one");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == STAT_FULL)) |-> w_full)
        else $error("full status on a list that is not full");

endmodule

`default_nettype wire

/* bench/indexed_list_insert_erase_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for indexed_list_insert_erase: directed table, then
// random grow/shrink/balanced phases, checked against an in-bench list model.
// Depends on ili_pkg, ili_if and the design.

module indexed_list_insert_erase_tb;
    import ili_pkg::*;

    localparam int RANDOM_WORDS = 1125;
    localparam int HOLD_AT      = 200;   // result number where the long hold starts
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_SHOWN    = 10;

    // Unused command codes; the block must ignore them
    localparam logic [CMD_W-1:0] CMD_JUNK_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_JUNK_HI = 3'd7;

    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fffffff;
    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh80000000;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  status;
    } t_list_reply;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               typed;   // expected reply given in the row
        t_list_reply        reply;
    } t_stim_row;

    localparam int N_ROWS = 25;
    localparam t_stim_row PLAN [0:N_ROWS-1] = '{
        '{CMD_READ,    6'd0,  32'd0,  1'b1, '{32'd0, 7'd0, STAT_RANGE}},
        '{CMD_POP,     6'd0,  32'd0,  1'b1, '{32'd0, 7'd0, STAT_EMPTY}},
        '{CMD_ERASE,   6'd0,  32'd0,  1'b1, '{32'd0, 7'd0, STAT_RANGE}},
        '{CMD_JUNK_LO, 6'd63, '1,     1'b1, '{32'd0, 7'd0, STAT_DONE}},
        '{CMD_JUNK_HI, 6'd0,  V_MAX,  1'b1, '{32'd0, 7'd0, STAT_DONE}},
        '{CMD_INSERT,  6'd0,  V_MAX,  1'b1, '{32'd0, 7'd1, STAT_DONE}},
        '{CMD_APPEND,  6'd63, V_MIN,  1'b1, '{32'd0, 7'd2, STAT_DONE}},
        '{CMD_READ,    6'd0,  32'd0,  1'b1, '{V_MAX, 7'd2, STAT_DONE}},
        '{CMD_READ,    6'd1,  '1,     1'b1, '{V_MIN, 7'd2, STAT_DONE}},
        '{CMD_INSERT,  6'd0,  '1,     1'b0, '0},
        '{CMD_INSERT,  6'd1,  32'h5a5a5a5a, 1'b0, '0},
        '{CMD_INSERT,  6'd63, 32'd0,  1'b0, '0},
        '{CMD_READ,    6'd0,  32'd0,  1'b0, '0},
        '{CMD_READ,    6'd2,  32'd0,  1'b0, '0},
        '{CMD_READ,    6'd4,  32'd0,  1'b0, '0},
        '{CMD_READ,    6'd5,  32'd0,  1'b1, '{32'd0, 7'd5, STAT_RANGE}},
        '{CMD_READ,    6'd63, 32'd0,  1'b1, '{32'd0, 7'd5, STAT_RANGE}},
        '{CMD_ERASE,   6'd0,  32'd0,  1'b0, '0},
        '{CMD_ERASE,   6'd3,  32'd0,  1'b0, '0},
        '{CMD_ERASE,   6'd63, 32'd0,  1'b1, '{32'd0, 7'd3, STAT_RANGE}},
        '{CMD_READ,    6'd1,  32'd0,  1'b0, '0},
        '{CMD_POP,     6'd0,  32'd0,  1'b0, '0},
        '{CMD_POP,     6'd0,  32'd0,  1'b0, '0},
        '{CMD_POP,     6'd0,  32'd0,  1'b0, '0},
        '{CMD_POP,     6'd0,  32'd0,  1'b1, '{32'd0, 7'd0, STAT_EMPTY}}
    };

    logic clk;
    logic rst_n;

    ili_cmd_if cmd_if ();
    ili_res_if res_if ();

    indexed_list_insert_erase dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // List model state
    logic [WORD_BITS-1:0] list_words [0:DEPTH-1];
    int                   list_held;

    t_list_reply pending_replies [$];
    int          mismatches;
    int          replies_seen;
    bit          quiet;      // no random idle gaps on either side while set

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Applies one command to the list model and returns its reply
    function automatic t_list_reply apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                   logic [INDEX_W-1:0] index,
                                                   logic [VALUE_W-1:0] value);
        t_list_reply r;
        int          pos;
        r = '0;
        r.status = STAT_DONE;
        case (cmd)
            CMD_APPEND, CMD_INSERT: begin
                if (list_held >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    pos = (cmd == CMD_APPEND || index >= list_held) ? list_held : index;
                    for (int i = list_held; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = value[WORD_BITS-1:0];
                    list_held++;
                end
            end
            CMD_POP: begin
                if (list_held == 0)
                    r.status = STAT_EMPTY;
                else
                    list_held--;
            end
            CMD_ERASE: begin
                if (index >= list_held) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (int i = index; i + 1 < list_held; i++)
                        list_words[i] = list_words[i+1];
                    list_held--;
                end
            end
            CMD_READ: begin
                if (index >= list_held)
                    r.status = STAT_RANGE;
                else
                    r.read_value = VALUE_W'(list_words[index]);
            end
            default: ;
        endcase
        r.count = COUNT_W'(list_held);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one command word, waits for it to be taken, then logs the reply
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] index,
                            logic [VALUE_W-1:0] value, bit typed, t_list_reply typed_reply);
        int          gap;
        t_list_reply r;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.cmd   <= cmd;
        cmd_if.index <= index;
        cmd_if.value <= value;
        @(posedge clk);
        while (!(cmd_if.valid && cmd_if.ready))
            @(posedge clk);
        r = apply_list_cmd(cmd, index, value);
        pending_replies = {pending_replies, (typed ? typed_reply : r)};
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return V_MAX;
        if (r < 10) return V_MIN;
        if (r < 13) return '0;
        if (r < 16) return '1;
        return $urandom;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 3) == 0 || list_held == 0)
            return INDEX_W'($urandom_range(0, 63));
        return INDEX_W'($urandom_range(0, (list_held > 63) ? 63 : list_held));
    endfunction

    // Command mix: 0 grow, 1 shrink, 2 balanced
    function automatic logic [CMD_W-1:0] pick_cmd(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (r < 45) return CMD_APPEND;
                if (r < 75) return CMD_INSERT;
                if (r < 85) return CMD_READ;
                if (r < 92) return CMD_ERASE;
                if (r < 97) return CMD_POP;
            end
            1: begin
                if (r < 10) return CMD_APPEND;
                if (r < 20) return CMD_INSERT;
                if (r < 35) return CMD_READ;
                if (r < 65) return CMD_ERASE;
                if (r < 95) return CMD_POP;
            end
            default: begin
                if (r < 20) return CMD_APPEND;
                if (r < 40) return CMD_INSERT;
                if (r < 65) return CMD_READ;
                if (r < 80) return CMD_ERASE;
                if (r < 95) return CMD_POP;
            end
        endcase
        return CMD_W'($urandom_range(CMD_JUNK_LO, CMD_JUNK_HI));
    endfunction

    // Command side
    initial begin
        int               sent;
        int               mode;
        int               run;
        cmd_if.valid <= 1'b0;
        cmd_if.cmd   <= CMD_APPEND;
        cmd_if.index <= '0;
        cmd_if.value <= '0;
        rst_n        <= 1'b0;
        list_held    = 0;
        mismatches   = 0;
        quiet        = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            list_words[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_cmd(PLAN[i].cmd, PLAN[i].index, PLAN[i].value, PLAN[i].typed,
                     PLAN[i].reply);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            mode  = $urandom_range(0, 2);
            run   = $urandom_range(30, 150);
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < run && sent < RANDOM_WORDS; k++) begin
                send_cmd(pick_cmd(mode), pick_index(), pick_value(), 1'b0, '0);
                sent++;
            end
        end
        quiet = 1'b0;
        cmd_if.valid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, one long hold to back up the list
    initial begin
        int          stall_left;
        t_list_reply got;
        t_list_reply want;
        stall_left   = 0;
        replies_seen = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.read_value, res_if.count, res_if.status};
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected word rd=%h cnt=%0d st=%0d", $time,
                                 got.read_value, got.count, got.status);
                end else begin
                    want = pending_replies.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: word %0d exp rd=%h cnt=%0d st=%0d",
                                     $time, replies_seen, want.read_value,
                                     want.count, want.status,
                                     ", got rd=%h cnt=%0d st=%0d",
                                     got.read_value, got.count, got.status);
                    end
                end
                if (replies_seen == HOLD_AT)
                    stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

endmodule

/* filelist.f */
design/ili_pkg.sv
design/ili_if.sv
design/ili_cell.sv
design/indexed_list_insert_erase.sv
bench/indexed_list_insert_erase_tb.sv
